// File: rtl/dqoi_pkg.sv
// Shared types and constants for the ordered-insert deque.
package dqoi_pkg;

  localparam int VAL_W        = 32;
  localparam int FUNC_W       = 3;
  localparam int POS_W        = 4;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_ORD_INS    = 3'd2,
    FN_POP_FRONT  = 3'd3,
    FN_POP_BACK   = 3'd4,
    FN_DEL_POS    = 3'd5
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INS,
    CMD_DEL
  } cmd_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic signed [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

// File: rtl/dqoi_in_if.sv
// Operation request channel.
interface dqoi_in_if import dqoi_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;

  modport source (output valid, func, value, position, input ready);
  modport sink   (input valid, func, value, position, output ready);
endinterface

// File: rtl/dqoi_out_if.sv
// Operation result channel.
interface dqoi_out_if import dqoi_pkg::*; #(
  parameter int CNT_W = $clog2(CAPACITY_DEF + 1)
);
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [CNT_W-1:0]        count;
  logic signed [VAL_W-1:0] head_value;
  logic signed [VAL_W-1:0] tail_value;

  modport source (output valid, status, count, head_value, tail_value, input ready);
  modport sink   (input valid, status, count, head_value, tail_value, output ready);
endinterface

// File: rtl/deque_with_ordered_insert.sv
// Top level: bounded ordered deque built from a row of shifting cells.
// Each operation steps through accept, compare, shift and report in order;
// a new input beat is taken only after the last result has been registered.
// All slots compare and shift in parallel; the sequencer sets the rate.
// A stalled result beat holds the report step and the input until it drains.
// Synchronous active-low reset empties the list and drops any pending result.
module deque_with_ordered_insert import dqoi_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dqoi_in_if.sink    in_ch,
  dqoi_out_if.source out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AT_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD, S_RPT} state_t;

  state_t                  state_r;
  logic [FUNC_W-1:0]       func_r;
  logic signed [VAL_W-1:0] value_r;
  logic [POS_W-1:0]        pos_r;
  logic [CNT_W-1:0]        count_r;
  logic [CAPACITY-1:0]     stop_r;
  status_t                 stat_r;
  logic                    out_valid_r;
  status_t                 out_status_r;
  logic [CNT_W-1:0]        out_count_r;
  logic signed [VAL_W-1:0] out_head_r;
  logic signed [VAL_W-1:0] out_tail_r;

  cmd_t                    cmd;
  status_t                 stat_nxt;
  logic [AT_W-1:0]         at;
  logic                    ordered;
  logic [CNT_W-1:0]        count_nxt;
  logic [AT_W-1:0]         count_ext;
  logic [AT_W-1:0]         pos_ext;
  cell_ctrl_t              ctrl;

  logic signed [VAL_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]     valid_vec;
  logic [CAPACITY-1:0]     sel_vec;
  logic [CAPACITY-1:0]     stop_vec;
  logic [CAPACITY-1:0]     tail_sel;
  logic signed [VAL_W-1:0] head_val;
  logic signed [VAL_W-1:0] tail_val;

  assign count_ext = AT_W'(count_r);
  assign pos_ext   = AT_W'(pos_r);

  always_comb begin
    cmd       = CMD_HOLD;
    stat_nxt  = ST_OK;
    at        = '0;
    ordered   = 1'b0;
    count_nxt = count_r;
    unique case (func_r)
      FN_PUSH_FRONT, FN_PUSH_BACK, FN_ORD_INS: begin
        if (count_r == CNT_W'(CAPACITY)) begin
          stat_nxt = ST_FULL;
        end else begin
          cmd       = CMD_INS;
          count_nxt = count_r + 1'b1;
          if (func_r == FN_PUSH_BACK) begin
            at = count_ext;
          end
          ordered = (func_r == FN_ORD_INS);
        end
      end
      FN_POP_FRONT, FN_POP_BACK, FN_DEL_POS: begin
        if (count_r == '0) begin
          stat_nxt = ST_EMPTY;
        end else if (func_r == FN_DEL_POS && pos_ext >= count_ext) begin
          stat_nxt = ST_BADPOS;
        end else begin
          cmd       = CMD_DEL;
          count_nxt = count_r - 1'b1;
          if (func_r == FN_POP_BACK) begin
            at = count_ext - 1'b1;
          end else if (func_r == FN_DEL_POS) begin
            at = pos_ext;
          end
        end
      end
      default: ;
    endcase
  end

  assign ctrl.cmd   = (state_r == S_UPD) ? cmd : CMD_HOLD;
  assign ctrl.value = value_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    sel_prev;
    logic signed [VAL_W-1:0] left_val;
    logic signed [VAL_W-1:0] right_val;

    assign valid_vec[i] = CNT_W'(i) < count_r;
    assign sel_vec[i]   = ordered ? (|stop_r[i:0]) : (AT_W'(i) >= at);

    if (i == 0) begin : g_first
      assign sel_prev = 1'b0;
      assign left_val = value_r;
    end else begin : g_mid
      assign sel_prev = sel_vec[i-1];
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val   = cell_val[i];
      assign tail_sel[i] = valid_vec[i];
    end else begin : g_inner
      assign right_val   = cell_val[i+1];
      assign tail_sel[i] = valid_vec[i] && !valid_vec[i+1];
    end

    dqoi_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .valid     (valid_vec[i]),
      .sel       (sel_vec[i]),
      .sel_prev  (sel_prev),
      .left_val  (left_val),
      .right_val (right_val),
      .val_r     (cell_val[i]),
      .stop      (stop_vec[i])
    );
  end

  assign head_val = valid_vec[0] ? cell_val[0] : '0;

  always_comb begin
    tail_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (tail_sel[i]) begin
        tail_val = tail_val | cell_val[i];
      end
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.count      = out_count_r;
  assign out_ch.head_value = out_head_r;
  assign out_ch.tail_value = out_tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_RPT && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            func_r  <= in_ch.func;
            value_r <= in_ch.value;
            pos_r   <= in_ch.position;
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          stop_r  <= stop_vec;
          state_r <= S_UPD;
        end
        S_UPD: begin
          count_r <= count_nxt;
          stat_r  <= stat_nxt;
          state_r <= S_RPT;
        end
        S_RPT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_status_r <= stat_r;
            out_count_r  <= count_r;
            out_head_r   <= head_val;
            out_tail_r   <= tail_val;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_result_from_report: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RPT))
    else $error("result raised outside report step");

  a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && stat_nxt != ST_OK) |=> count_r == $past(count_r))
    else $error("rejected operation changed the count");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && cmd == CMD_INS) |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the list");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && cmd == CMD_DEL) |=> count_r == $past(count_r) - 1'b1)
    else $error("delete did not shrink the list");

endmodule

// File: rtl/dqoi_cell.sv
// One list slot: holds an entry, compares it, and shifts with its neighbors.
module dqoi_cell import dqoi_pkg::*; (
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic                    valid,
  input  logic                    sel,
  input  logic                    sel_prev,
  input  logic signed [VAL_W-1:0] left_val,
  input  logic signed [VAL_W-1:0] right_val,
  output logic signed [VAL_W-1:0] val_r,
  output logic                    stop
);

  logic signed [VAL_W-1:0] val_nxt;

  // stop if empty or val_r >= value; an ordered insert takes the first one
  assign stop = !valid || !(val_r < ctrl.value);

  always_comb begin
    val_nxt = val_r;
    unique case (ctrl.cmd)
      CMD_INS: begin
        if (sel) begin
          val_nxt = sel_prev ? left_val : ctrl.value;
        end
      end
      CMD_DEL: begin
        if (sel) begin
          val_nxt = right_val;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the ordered-insert deque: directed and random list operations.
`timescale 1ns / 1ps

module testbench;
  import dqoi_pkg::*;

  localparam int                CAPACITY    = CAPACITY_DEF;
  localparam int                CNT_W       = $clog2(CAPACITY + 1);
  localparam int                CYCLE_LIMIT = 400000;
  localparam int                DRAIN_WAIT  = 20;
  localparam int                PRINT_CAP   = 40;
  localparam logic [FUNC_W-1:0] FN_SPARE_6  = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7  = 3'd7;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic [FUNC_W-1:0]       func;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } list_op_t;

  typedef struct {
    status_t                 status;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] head;
    logic signed [VAL_W-1:0] tail;
  } list_reply_t;

  logic clk;
  logic rst_n;

  dqoi_in_if                  in_ch ();
  dqoi_out_if #(.CNT_W(CNT_W)) out_ch ();

  deque_with_ordered_insert #(.CAPACITY(CAPACITY)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  list_op_t                ops_to_send[$];
  list_reply_t             replies_due[$];
  logic signed [VAL_W-1:0] list_image[$];
  list_op_t                next_op;
  list_reply_t             due;
  list_reply_t             rx_due;
  int unsigned             send_idle_pct;
  int unsigned             recv_stall_pct;
  bit                      hold_sender;
  int                      errors = 0;
  int                      ops_accepted;
  int                      replies_checked;
  int                      status_seen[4];
  int                      cycles = 0;
  func_t                   ins_kinds[3] = '{FN_PUSH_FRONT, FN_PUSH_BACK, FN_ORD_INS};
  func_t                   del_kinds[3] = '{FN_POP_FRONT, FN_POP_BACK, FN_DEL_POS};

  function automatic list_op_t make_op(logic [FUNC_W-1:0] f, logic signed [VAL_W-1:0] v,
                                       logic [POS_W-1:0] p);
    list_op_t op;
    op.func     = f;
    op.value    = v;
    op.position = p;
    return op;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned             sel;
    logic signed [VAL_W-1:0] v;
    sel = $urandom_range(99);
    if (sel < 40) begin
      v = int'($urandom_range(16)) - 8;
    end else if (sel < 55) begin
      case ($urandom_range(4))
        0: v = VAL_MIN;
        1: v = VAL_MAX;
        2: v = 0;
        3: v = -1;
        default: v = 1;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // Update the list image and return the reply the block owes.
  function automatic list_reply_t apply_list_op(list_op_t op);
    list_reply_t r;
    int          idx;
    r.status = ST_OK;
    case (op.func)
      FN_PUSH_FRONT, FN_PUSH_BACK, FN_ORD_INS: begin
        if (list_image.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (op.func == FN_PUSH_FRONT) begin
          list_image.push_front(op.value);
        end else if (op.func == FN_PUSH_BACK) begin
          list_image.push_back(op.value);
        end else begin
          idx = 0;
          while (idx < list_image.size() && list_image[idx] < op.value) idx++;
          list_image.insert(idx, op.value);
        end
      end
      FN_POP_FRONT, FN_POP_BACK, FN_DEL_POS: begin
        if (list_image.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (op.func == FN_POP_FRONT) begin
          void'(list_image.pop_front());
        end else if (op.func == FN_POP_BACK) begin
          void'(list_image.pop_back());
        end else if (op.position >= list_image.size()) begin
          r.status = ST_BADPOS;
        end else begin
          list_image.delete(op.position);
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(list_image.size());
    if (list_image.size() == 0) begin
      r.head = 0;
      r.tail = 0;
    end else begin
      r.head = list_image[0];
      r.tail = list_image[list_image.size() - 1];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (errors < PRINT_CAP) begin
      $display("mismatch at reply %0d: %s got %0d want %0d", replies_checked, what, got, want);
    end
    errors++;
  endtask

  // Generate bursts that lean toward filling or draining the list.
  task automatic gen_random_ops(int n);
    int                left;
    int                burst;
    int unsigned       ins_pct;
    logic [FUNC_W-1:0] f;
    logic [POS_W-1:0]  p;
    left = n;
    while (left > 0) begin
      burst   = $urandom_range(40, 4);
      ins_pct = $urandom_range(90, 10);
      for (int k = 0; k < burst && left > 0; k++) begin
        if ($urandom_range(99) < 3) begin
          f = $urandom_range(1) ? FN_SPARE_6 : FN_SPARE_7;
        end else if ($urandom_range(99) < ins_pct) begin
          f = ($urandom_range(3) >= 2) ? FN_ORD_INS : ins_kinds[$urandom_range(1)];
        end else begin
          f = del_kinds[$urandom_range(2)];
        end
        p = ($urandom_range(99) < 60) ? POS_W'($urandom_range(7)) : POS_W'($urandom_range(15));
        ops_to_send.push_back(make_op(f, pick_value(), p));
        left--;
      end
    end
  endtask

  task automatic wait_sent();
    while (ops_to_send.size() != 0 || in_ch.valid) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies still due", cycles, replies_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Sender: predict on each accepted beat, then offer the next op or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        due = apply_list_op(make_op(in_ch.func, in_ch.value, in_ch.position));
        status_seen[due.status]++;
        replies_due.push_back(due);
        ops_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (ops_to_send.size() != 0 && !hold_sender &&
            $urandom_range(99) >= send_idle_pct) begin
          next_op = ops_to_send.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.func     <= next_op.func;
          in_ch.value    <= next_op.value;
          in_ch.position <= next_op.position;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall at random, check each reply beat against the oldest one due.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("reply with none due, count", out_ch.count, 0);
        end else begin
          rx_due = replies_due.pop_front();
          if (out_ch.status !== rx_due.status)
            report_mismatch("status", out_ch.status, rx_due.status);
          if (out_ch.count !== rx_due.count)
            report_mismatch("count", out_ch.count, rx_due.count);
          if (out_ch.head_value !== rx_due.head)
            report_mismatch("head_value", out_ch.head_value, rx_due.head);
          if (out_ch.tail_value !== rx_due.tail)
            report_mismatch("tail_value", out_ch.tail_value, rx_due.tail);
        end
        replies_checked++;
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_sender    = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-list deletes, front insert into empty, equal-to-head
    // ordered insert, extremes, bad position, spare code, then fill past full.
    ops_to_send.push_back(make_op(FN_POP_FRONT, 0, 0));
    ops_to_send.push_back(make_op(FN_DEL_POS, -1, 4'hF));
    ops_to_send.push_back(make_op(FN_PUSH_FRONT, 5, 0));
    ops_to_send.push_back(make_op(FN_ORD_INS, 5, 0));
    ops_to_send.push_back(make_op(FN_ORD_INS, VAL_MIN, 0));
    ops_to_send.push_back(make_op(FN_ORD_INS, VAL_MAX, 0));
    ops_to_send.push_back(make_op(FN_PUSH_BACK, -1, 0));
    ops_to_send.push_back(make_op(FN_DEL_POS, 0, 4'hF));
    ops_to_send.push_back(make_op(FN_DEL_POS, 0, 1));
    ops_to_send.push_back(make_op(FN_POP_BACK, 0, 0));
    ops_to_send.push_back(make_op(FN_SPARE_7, -1, 4'hF));
    for (int k = 0; k < 14; k++)
      ops_to_send.push_back(make_op(ins_kinds[k % 3], pick_value(), 0));
    gen_random_ops(440);
    wait_sent();

    for (int ph = 1; ph < 4; ph++) begin
      // Hold off the sender until every reply has drained.
      hold_sender = 1'b1;
      while (replies_due.size() != 0) @(posedge clk);
      hold_sender = 1'b0;
      case (ph)
        1: begin send_idle_pct = 77; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      gen_random_ops(440);
      wait_sent();
    end

    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("summary: %0d operations accepted, %0d replies checked across four pacing phases",
             ops_accepted, replies_checked);
    $display("summary: status ok %0d, empty %0d, full %0d, bad position %0d, mismatches %0d",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
             status_seen[ST_BADPOS], errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
